FILE: src/svt_pkg.sv
`timescale 1ns / 1ps

package svt_pkg;

    // table size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // request codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // shared command broadcast to every cell
    typedef struct packed {
        logic                     insert_en;
        logic                     delete_en;
        logic signed [DATA_W-1:0] value;
    } svt_cmd_t;

    // per-cell compare flags seen by the top level
    typedef struct packed {
        logic lt;
        logic eq;
        logic first;
    } svt_flags_t;

endpackage

FILE: src/svt_cell.sv
`timescale 1ns / 1ps

module svt_cell
    import svt_pkg::*;
(
    input  logic                     clk,
    input  svt_cmd_t                 cmd,
    input  logic                     valid,
    input  logic                     prev_lt,
    input  logic signed [DATA_W-1:0] prev_entry,
    input  logic signed [DATA_W-1:0] next_entry,
    output logic signed [DATA_W-1:0] entry,
    output svt_flags_t               flags
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    // local compare against the request value
    always_comb
    begin
        flags.lt    = valid && (entry_reg < cmd.value);
        flags.eq    = valid && (entry_reg == cmd.value);
        flags.first = flags.eq && prev_lt;
    end

    // insert shifts up from the left neighbor, delete pulls from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert_en && !flags.lt)
        begin
            entry_next = prev_lt ? cmd.value : prev_entry;
        end
        else if (cmd.delete_en && !flags.lt)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: src/sorted_value_table_unit.sv
`timescale 1ns / 1ps
// a result is registered and appears in the cycle after its request is accepted
// throughput: one transaction per cycle unless a held result drops in_ready;
// one cell per entry, all cells compare and shift in the same cycle; no op iterates
// reset: rst_n clears the entry count and the result valid flag; the entry
// registers hold no reset value and are read only below the count

module sorted_value_table_unit
    import svt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         position,
    output logic [CNT_W-1:0]         count
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [CNT_W-1:0]         position_reg;
    logic [CNT_W-1:0]         position_next;

    logic                     accept;
    logic                     full;
    logic                     found;
    svt_cmd_t                 cmd;
    logic                     cell_valid [CAPACITY];
    logic signed [DATA_W-1:0] cell_entry [CAPACITY];
    svt_flags_t               cell_flags [CAPACITY];
    logic                     cell_prev_lt [CAPACITY];
    logic signed [DATA_W-1:0] cell_prev [CAPACITY];
    logic signed [DATA_W-1:0] cell_next [CAPACITY];

    // result register frees when empty or being taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));

    // found and first-match position over all cells; zero position unless a search
    always_comb
    begin
        found    = 1'b0;
        position_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found = found | cell_flags[i].eq;
            if (cell_flags[i].first)
            begin
                position_next = position_next | CNT_W'(i + 1);
            end
        end
        if (op != OP_SEARCH)
        begin
            position_next = '0;
        end
    end

    // command broadcast
    always_comb
    begin
        cmd.insert_en = accept && (op == OP_INSERT) && !full;
        cmd.delete_en = accept && (op == OP_DELETE) && found;
        cmd.value     = value;
    end

    // next count and status
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        unique case (op)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            OP_SEARCH:
            begin
                if (!found)
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // neighbor wiring of the cell row
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_valid[i] = (CNT_W'(i) < count_reg);
            if (i == 0)
            begin
                cell_prev_lt[i] = 1'b1;
                cell_prev[i]    = value;
            end
            else
            begin
                cell_prev_lt[i] = cell_flags[i-1].lt;
                cell_prev[i]    = cell_entry[i-1];
            end
            if (i == CAPACITY - 1)
            begin
                cell_next[i] = cell_entry[i];
            end
            else
            begin
                cell_next[i] = cell_entry[i+1];
            end
        end
    end

    // one cell per table slot
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        svt_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .valid      (cell_valid[g]),
            .prev_lt    (cell_prev_lt[g]),
            .prev_entry (cell_prev[g]),
            .next_entry (cell_next[g]),
            .entry      (cell_entry[g]),
            .flags      (cell_flags[g])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign count     = count_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_CLEAR) |=> (count_reg == '0 && out_valid_reg))
        else $error("clear did not empty the table");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_INSERT && full) |=> (status_reg == ST_FULL && full))
        else $error("insert into full table not flagged");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a transaction");

endmodule
